FILE: src/tba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tba_pkg: shared types and constants of the time bucket aggregator
// widths, aggregate codes, register indexes and divider handshake structs
// ----------------------------------------------------------------------------
package tba_pkg;

  localparam int TIME_WIDTH      = 48;
  localparam int VALUE_WIDTH     = 32;
  localparam int QUALITY_WIDTH   = 8;
  localparam int RESULT_WIDTH    = 64;
  localparam int COUNT_WIDTH     = 32;
  localparam int MODE_WIDTH      = 3;
  localparam int INTERVAL_WIDTH  = 48;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 48;
  localparam int FRAC_BITS       = 16;

  // divisor must hold either the bucket interval or the item count
  localparam int DIV_WIDTH      = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
  localparam int DIV_STEP_WIDTH = $clog2(RESULT_WIDTH);

  typedef logic [MODE_WIDTH-1:0] mode_t;

  localparam mode_t MODE_TOTAL   = mode_t'(0);
  localparam mode_t MODE_AVERAGE = mode_t'(1);
  localparam mode_t MODE_COUNT   = mode_t'(2);
  localparam mode_t MODE_MINIMUM = mode_t'(3);
  localparam mode_t MODE_MAXIMUM = mode_t'(4);
  localparam mode_t MODE_FIRST   = mode_t'(5);
  localparam mode_t MODE_LAST    = mode_t'(6);

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_AGGREGATE_MODE  = cfg_index_t'(0);
  localparam cfg_index_t REG_BUCKET_INTERVAL = cfg_index_t'(1);

  localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = INTERVAL_WIDTH'(1000);

  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic signed [RESULT_WIDTH-1:0] RESULT_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
  localparam logic signed [RESULT_WIDTH-1:0] RESULT_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic                    start;
    logic [RESULT_WIDTH-1:0] dividend;
    logic [DIV_WIDTH-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [RESULT_WIDTH-1:0] quotient;
    logic [DIV_WIDTH-1:0]    remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: src/tba_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tba_sample_if: sample channel
// valid/ready channel carrying one time-stamped sample per beat
// ----------------------------------------------------------------------------
interface tba_sample_if import tba_pkg::*; ();

  logic                            valid;
  logic                            ready;
  logic [TIME_WIDTH-1:0]           sample_time;
  logic signed [VALUE_WIDTH-1:0]   sample_value;
  logic                            value_valid;
  logic [QUALITY_WIDTH-1:0]        sample_quality;
  logic                            range_last;

  modport source (
    output valid, sample_time, sample_value, value_valid, sample_quality, range_last,
    input  ready
  );

  modport sink (
    input  valid, sample_time, sample_value, value_valid, sample_quality, range_last,
    output ready
  );

endinterface
`default_nettype wire

FILE: src/tba_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tba_result_if: bucket result channel
// valid/ready channel carrying one bucket aggregate per beat
// ----------------------------------------------------------------------------
interface tba_result_if import tba_pkg::*; ();

  logic                             valid;
  logic                             ready;
  logic [TIME_WIDTH-1:0]            bucket_start;
  logic signed [RESULT_WIDTH-1:0]   result_value;
  logic [QUALITY_WIDTH-1:0]         result_quality;
  logic                             result_last;

  modport source (
    output valid, bucket_start, result_value, result_quality, result_last,
    input  ready
  );

  modport sink (
    input  valid, bucket_start, result_value, result_quality, result_last,
    output ready
  );

endinterface
`default_nettype wire

FILE: src/tba_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tba_div: iterative unsigned divider
// restoring division, one quotient bit per cycle, shared for the bucket
// modulo and the bucket average
// ----------------------------------------------------------------------------
module tba_div import tba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                      busy;
  logic                      done;
  logic [DIV_STEP_WIDTH-1:0] step;
  logic [DIV_WIDTH-1:0]      rem;
  logic [RESULT_WIDTH-1:0]   dq;
  logic [DIV_WIDTH-1:0]      dvs;

  logic [DIV_WIDTH:0] trial;
  logic [DIV_WIDTH:0] diff;
  logic               qbit;

  assign trial = {rem, dq[RESULT_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_STEP_WIDTH'(RESULT_WIDTH-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      dq  <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= qbit ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      dq  <= {dq[RESULT_WIDTH-2:0], qbit};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dq;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

FILE: src/time_bucket_aggregator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_bucket_aggregator: time-interval aggregation over aligned buckets
// groups time-sorted Q16.16 samples into epoch-aligned buckets and reports
// one Q47.16 aggregate (total, average, count, min, max, first, last) each
// ----------------------------------------------------------------------------
// Samples are taken one at a time. Each sample's bucket start (time minus
// time mod interval) comes from a 64-step restoring divider, or is the sample
// time itself when the interval is zero, and a new sample is only taken once
// the block is done with the last one, including loading any result it forms.
// In average mode the same divider forms sum / count before a result is
// loaded. The divider is the only long-latency unit. Results sit in an output
// register, so the block goes back to taking samples while the last result
// waits; it only stalls when a new result is ready and the previous one has
// not yet been taken. Configuration (aggregate mode, bucket interval) is
// written through a plain write port and must only change while the block is
// idle; the mode is applied when a result is formed and when a minimum or
// maximum is updated.
// ----------------------------------------------------------------------------
module time_bucket_aggregator import tba_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  tba_sample_if.sink                      samples,
  tba_result_if.source                    results
);

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a sample beat
    ST_MOD,     // divider computing time mod interval
    ST_CHECK,   // compare bucket start with the open bucket
    ST_PREP,    // kick the divider for an average, if needed
    ST_AVG,     // divider computing sum / count
    ST_EMIT,    // load the output register
    ST_UPDATE   // fold the sample into the bucket
  } state_t;

  state_t state;

  // configuration registers
  mode_t                     aggregate_mode;
  logic [INTERVAL_WIDTH-1:0] bucket_interval;
  logic [TIME_WIDTH-1:0]     interval;

  // captured sample
  logic [TIME_WIDTH-1:0]         s_time;
  logic signed [VALUE_WIDTH-1:0] s_value;
  logic                          s_valid;
  logic [QUALITY_WIDTH-1:0]      s_quality;
  logic                          s_last;
  logic [TIME_WIDTH-1:0]         s_start;

  // open bucket state
  logic                           bucket_open;
  logic [TIME_WIDTH-1:0]          open_start;
  logic signed [RESULT_WIDTH-1:0] running_sum;
  logic [COUNT_WIDTH-1:0]         item_count;
  logic signed [VALUE_WIDTH-1:0]  extreme_value;
  logic [QUALITY_WIDTH-1:0]       extreme_quality;
  logic                           extreme_seen;
  logic signed [VALUE_WIDTH-1:0]  first_value;
  logic [QUALITY_WIDTH-1:0]       first_quality;
  logic signed [VALUE_WIDTH-1:0]  latest_value;
  logic [QUALITY_WIDTH-1:0]       latest_quality;

  // result staging
  logic                           emit_last;
  logic signed [RESULT_WIDTH-1:0] avg_value;

  // output register
  logic                           out_valid;
  logic [TIME_WIDTH-1:0]          out_start;
  logic signed [RESULT_WIDTH-1:0] out_value;
  logic [QUALITY_WIDTH-1:0]       out_quality;
  logic                           out_last;

  logic in_accept;
  logic out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign interval  = TIME_WIDTH'(bucket_interval);
  assign in_accept = samples.valid && samples.ready;
  assign out_free  = !out_valid || results.ready;

  assign samples.ready          = (state == ST_IDLE);
  assign results.valid          = out_valid;
  assign results.bucket_start   = out_start;
  assign results.result_value   = out_value;
  assign results.result_quality = out_quality;
  assign results.result_last    = out_last;

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      aggregate_mode  <= MODE_TOTAL;
      bucket_interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AGGREGATE_MODE:  aggregate_mode  <= MODE_WIDTH'(cfg_data);
        REG_BUCKET_INTERVAL: bucket_interval <= INTERVAL_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // ---- shared divider ----

  // magnitude of the sum for a truncate-toward-zero average
  logic                    sum_neg;
  logic [RESULT_WIDTH-1:0] sum_mag;
  logic [DIV_WIDTH-1:0]    count_divisor;

  assign sum_neg       = running_sum[RESULT_WIDTH-1];
  assign sum_mag       = sum_neg ? (~running_sum + 1'b1) : running_sum;
  assign count_divisor = (item_count != '0) ? DIV_WIDTH'(item_count) : DIV_WIDTH'(1);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = RESULT_WIDTH'(samples.sample_time);
    div_req.divisor  = DIV_WIDTH'(interval);
    case (state)
      ST_IDLE: begin
        // a zero interval puts each sample in a bucket at its own time
        div_req.start = in_accept && (interval != '0);
      end
      ST_PREP: begin
        div_req.start    = (aggregate_mode == MODE_AVERAGE);
        div_req.dividend = sum_mag;
        div_req.divisor  = count_divisor;
      end
      default: ;
    endcase
  end

  tba_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---- bucket update ----

  logic                           opening;
  logic signed [VALUE_WIDTH-1:0]  ext_cur;
  logic                           seen_cur;
  logic signed [RESULT_WIDTH-1:0] sum_cur;
  logic [COUNT_WIDTH-1:0]         count_cur;
  logic signed [RESULT_WIDTH:0]   sum_wide;
  logic signed [RESULT_WIDTH-1:0] sum_next;
  logic [COUNT_WIDTH-1:0]         count_next;
  logic                           take_extreme;

  assign opening   = !bucket_open;
  assign ext_cur   = opening ? ((aggregate_mode == MODE_MAXIMUM) ? VALUE_MIN : VALUE_MAX)
                             : extreme_value;
  assign seen_cur  = opening ? 1'b0 : extreme_seen;
  assign sum_cur   = opening ? '0 : running_sum;
  assign count_cur = opening ? '0 : item_count;

  // saturating add: top two bits disagree on overflow
  assign sum_wide = (RESULT_WIDTH+1)'(sum_cur) + (RESULT_WIDTH+1)'(s_value);
  always_comb begin
    if (sum_wide[RESULT_WIDTH] != sum_wide[RESULT_WIDTH-1]) begin
      sum_next = sum_wide[RESULT_WIDTH] ? RESULT_MIN : RESULT_MAX;
    end else begin
      sum_next = sum_wide[RESULT_WIDTH-1:0];
    end
  end

  assign count_next = (count_cur != COUNT_MAX) ? count_cur + 1'b1 : count_cur;

  // strict compare, so the earliest sample at the extreme keeps its quality
  always_comb begin
    if (aggregate_mode == MODE_MAXIMUM) begin
      take_extreme = (s_value > ext_cur) || (!seen_cur && (s_value == ext_cur));
    end else begin
      take_extreme = (s_value < ext_cur) || (!seen_cur && (s_value == ext_cur));
    end
  end

  // ---- result selection ----

  logic signed [RESULT_WIDTH-1:0] emit_value;
  logic [QUALITY_WIDTH-1:0]       emit_quality;

  always_comb begin
    emit_value   = '0;
    emit_quality = '0;
    case (aggregate_mode)
      MODE_TOTAL:   emit_value = running_sum;
      MODE_AVERAGE: emit_value = avg_value;
      MODE_COUNT:   emit_value = RESULT_WIDTH'(item_count) << FRAC_BITS;
      MODE_MINIMUM, MODE_MAXIMUM: begin
        emit_value   = RESULT_WIDTH'(extreme_value);
        emit_quality = extreme_seen ? extreme_quality : '0;
      end
      MODE_FIRST: begin
        emit_value   = RESULT_WIDTH'(first_value);
        emit_quality = first_quality;
      end
      MODE_LAST: begin
        emit_value   = RESULT_WIDTH'(latest_value);
        emit_quality = latest_quality;
      end
      default: ;
    endcase
  end

  // ---- sequencer ----

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      bucket_open <= 1'b0;
      out_valid   <= 1'b0;
      emit_last   <= 1'b0;
    end else begin
      if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            s_time    <= samples.sample_time;
            s_value   <= samples.sample_value;
            s_valid   <= samples.value_valid;
            s_quality <= samples.sample_quality;
            s_last    <= samples.range_last;
            s_start   <= samples.sample_time;
            state     <= (interval != '0) ? ST_MOD : ST_CHECK;
          end
        end
        ST_MOD: begin
          if (div_rsp.done) begin
            s_start <= s_time - TIME_WIDTH'(div_rsp.remainder);
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // a new bucket start closes the open bucket first
          if (bucket_open && (s_start != open_start)) begin
            emit_last <= 1'b0;
            state     <= ST_PREP;
          end else begin
            state <= ST_UPDATE;
          end
        end
        ST_PREP: begin
          state <= (aggregate_mode == MODE_AVERAGE) ? ST_AVG : ST_EMIT;
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            avg_value <= sum_neg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_start   <= open_start;
            out_value   <= emit_value;
            out_quality <= emit_quality;
            out_last    <= emit_last;
            bucket_open <= 1'b0;
            state       <= emit_last ? ST_IDLE : ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          bucket_open    <= 1'b1;
          latest_value   <= s_value;
          latest_quality <= s_quality;
          item_count     <= count_next;
          if (opening) begin
            open_start    <= s_start;
            first_value   <= s_value;
            first_quality <= s_quality;
          end
          if (s_valid) begin
            running_sum  <= sum_next;
            extreme_seen <= 1'b1;
            if (take_extreme) begin
              extreme_value   <= s_value;
              extreme_quality <= s_quality;
            end else begin
              extreme_value   <= ext_cur;
              extreme_quality <= opening ? '0 : extreme_quality;
            end
          end else begin
            running_sum     <= sum_cur;
            extreme_seen    <= seen_cur;
            extreme_value   <= ext_cur;
            extreme_quality <= opening ? '0 : extreme_quality;
          end
          // range end flushes the bucket just updated
          if (s_last) begin
            emit_last <= 1'b1;
            state     <= ST_PREP;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---- checks ----

  // the divider only finishes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_MOD || state == ST_AVG))
    else $error("divider finished outside a wait state");

  // an open bucket always holds at least one sample
  assert property (@(posedge clk) disable iff (rst)
    bucket_open |-> (item_count != '0))
    else $error("open bucket with zero count");

  // a flush result shows up flagged as the range end
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && emit_last) |=> (results.valid && results.result_last))
    else $error("range flush not presented as last");

  // an accepted sample goes straight to bucket start work
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_MOD || state == ST_CHECK))
    else $error("sample beat not followed by bucket start work");

endmodule
`default_nettype wire

FILE: tb/time_bucket_aggregator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_bucket_aggregator_test: self-checking bench for the bucket aggregator
// drives time-stamped samples over the sample channel and checks every bucket
// result beat against an in-bench aggregator model; a directed table with
// hand-worked answers comes first, then randomized bucket sequences under
// several register settings, idling patterns and one long output hold-off
// ----------------------------------------------------------------------------
module time_bucket_aggregator_test;
  import tba_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 12;
  localparam int DRAIN_CYCLES    = 256;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int SEGMENTS        = 10;
  localparam int SEGMENT_ITEMS   = 40;
  localparam int MAX_REPORTS     = 10;
  localparam int DIRECTED_ROWS   = 24;
  localparam int STEP_CAP        = 1 << 20;

  // code seven has no aggregate, the block must report zero
  localparam mode_t MODE_UNUSED = mode_t'(7);
  localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_TOP = '1;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]           stamp;
    logic signed [VALUE_WIDTH-1:0]   value;
    logic                            ok;
    logic [QUALITY_WIDTH-1:0]        quality;
    logic                            last;
  } sample_item_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]           start;
    logic signed [RESULT_WIDTH-1:0]  value;
    logic [QUALITY_WIDTH-1:0]        quality;
    logic                            last;
  } bucket_result_t;

  // one row of the directed table: optional register writes, one sample, and
  // where it is obvious by hand the final bucket result that sample flushes
  typedef struct packed {
    logic                            set_mode;
    mode_t                           mode;
    logic                            set_interval;
    logic [INTERVAL_WIDTH-1:0]       interval;
    sample_item_t                    item;
    logic                            known;
    bucket_result_t                  outcome;
  } directed_row_t;

  localparam bucket_result_t NO_RESULT = '0;

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  logic                       rst;
  logic                       cfg_we;
  cfg_index_t                 cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  tba_sample_if samp ();
  tba_result_if res ();

  time_bucket_aggregator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samp),
    .results   (res)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  logic pressure_active    = 1'b0;

  int mismatch_count  = 0;
  int samples_taken   = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int input_stall_run = 0;
  int max_input_stall = 0;

  // bucket results still owed by the block, oldest first
  bucket_result_t pending_buckets [$];

  // aggregator model: register copies and the open bucket
  mode_t                          cfg_mode;
  logic [INTERVAL_WIDTH-1:0]      cfg_interval;
  logic                           have_bucket;
  logic [TIME_WIDTH-1:0]          cur_bucket_start;
  logic signed [RESULT_WIDTH-1:0] bucket_total;
  logic [COUNT_WIDTH-1:0]         bucket_count;
  logic signed [VALUE_WIDTH-1:0]  bucket_extreme;
  logic [QUALITY_WIDTH-1:0]       extreme_qual;
  logic                           extreme_hit;
  sample_item_t                   bucket_first;
  sample_item_t                   bucket_latest;

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // total after reset, interval 1000 from reset
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd1500, 32'h0001_0000, 1'b1, 8'h5A, 1'b1},
      1'b1, '{48'd1000, 64'h0000_0000_0001_0000, 8'h00, 1'b1}},
    // last sample is reported even when not numeric
    '{1'b1, MODE_LAST, 1'b0, 48'd0, '{48'd2000, 32'hFFFF_0000, 1'b0, 8'hFF, 1'b1},
      1'b1, '{48'd2000, 64'hFFFF_FFFF_FFFF_0000, 8'hFF, 1'b1}},
    // minimum: most positive value, in a sample on the upper edge of the bucket
    '{1'b1, MODE_MINIMUM, 1'b0, 48'd0, '{48'd2999, 32'h7FFF_FFFF, 1'b1, 8'h01, 1'b0},
      1'b0, NO_RESULT},
    // next bucket opens at exactly start + interval (half-open), then flushes
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd3000, 32'h8000_0000, 1'b1, 8'h80, 1'b1},
      1'b1, '{48'd3000, 64'hFFFF_FFFF_8000_0000, 8'h80, 1'b1}},
    // maximum with no numeric value holds the most negative start value
    '{1'b1, MODE_MAXIMUM, 1'b0, 48'd0, '{48'd4000, 32'h0005_0000, 1'b0, 8'h03, 1'b1},
      1'b1, '{48'd4000, 64'hFFFF_FFFF_8000_0000, 8'h00, 1'b1}},
    // minimum with no numeric value
    '{1'b1, MODE_MINIMUM, 1'b0, 48'd0, '{48'd5000, 32'h0007_0000, 1'b0, 8'h03, 1'b1},
      1'b1, '{48'd5000, 64'h0000_0000_7FFF_FFFF, 8'h00, 1'b1}},
    // count includes samples that are not numeric
    '{1'b1, MODE_COUNT, 1'b0, 48'd0, '{48'd6000, 32'h0000_0000, 1'b0, 8'h00, 1'b0},
      1'b0, NO_RESULT},
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd6001, 32'h0001_0000, 1'b1, 8'h10, 1'b0},
      1'b0, NO_RESULT},
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd6999, 32'hFFFF_FFFF, 1'b0, 8'h20, 1'b1},
      1'b1, '{48'd6000, 64'h0000_0000_0003_0000, 8'h00, 1'b1}},
    // average of a negative total truncates toward zero: -3 / 2 -> -1
    '{1'b1, MODE_AVERAGE, 1'b0, 48'd0, '{48'd7000, 32'hFFFF_FFFD, 1'b1, 8'h00, 1'b0},
      1'b0, NO_RESULT},
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd7001, 32'h0000_0000, 1'b0, 8'h00, 1'b1},
      1'b1, '{48'd7000, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1}},
    // first sample of the bucket
    '{1'b1, MODE_FIRST, 1'b0, 48'd0, '{48'd8000, 32'h0000_1234, 1'b0, 8'h11, 1'b0},
      1'b0, NO_RESULT},
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd8500, 32'h0000_5678, 1'b1, 8'h22, 1'b1},
      1'b1, '{48'd8000, 64'h0000_0000_0000_1234, 8'h11, 1'b1}},
    // widest interval: top time values fall into two different buckets
    '{1'b1, MODE_TOTAL, 1'b1, 48'hFFFF_FFFF_FFFF,
      '{48'hFFFF_FFFF_FFFE, 32'h7FFF_FFFF, 1'b1, 8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 8'h00, 1'b1},
      1'b1, '{48'hFFFF_FFFF_FFFF, 64'h0000_0000_7FFF_FFFF, 8'h00, 1'b1}},
    // interval one, then time running backward closes the open bucket
    '{1'b0, MODE_TOTAL, 1'b1, 48'd1, '{48'd100, 32'h0002_0000, 1'b1, 8'h00, 1'b0},
      1'b0, NO_RESULT},
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd50, 32'h0003_0000, 1'b1, 8'h00, 1'b0},
      1'b0, NO_RESULT},
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd50, 32'h0004_0000, 1'b1, 8'h0F, 1'b1},
      1'b1, '{48'd50, 64'h0000_0000_0007_0000, 8'h00, 1'b1}},
    // unused mode code reports zero
    '{1'b1, MODE_UNUSED, 1'b0, 48'd0, '{48'd60, 32'h0009_0000, 1'b1, 8'h44, 1'b1},
      1'b1, '{48'd60, 64'h0, 8'h00, 1'b1}},
    // zero interval: the bucket starts at the sample's own time
    '{1'b1, MODE_TOTAL, 1'b1, 48'd0, '{48'h1234_5678_9ABC, 32'h0001_0000, 1'b1, 8'h00, 1'b1},
      1'b1, '{48'h1234_5678_9ABC, 64'h0000_0000_0001_0000, 8'h00, 1'b1}},
    // mode switched from minimum to maximum while a bucket is open
    '{1'b1, MODE_MINIMUM, 1'b1, 48'd10, '{48'd200, 32'h0005_0000, 1'b1, 8'h01, 1'b0},
      1'b0, NO_RESULT},
    '{1'b1, MODE_MAXIMUM, 1'b0, 48'd0, '{48'd205, 32'h0003_0000, 1'b1, 8'h02, 1'b0},
      1'b0, NO_RESULT},
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd209, 32'h0004_0000, 1'b1, 8'h03, 1'b1},
      1'b0, NO_RESULT},
    // maximum on a sample equal to the most negative value takes its quality
    '{1'b0, MODE_TOTAL, 1'b0, 48'd0, '{48'd300, 32'h8000_0000, 1'b1, 8'h77, 1'b1},
      1'b1, '{48'd300, 64'hFFFF_FFFF_8000_0000, 8'h77, 1'b1}}
  };

  // --------------------------------------------------------------------------
  // aggregator model
  // --------------------------------------------------------------------------
  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic signed [RESULT_WIDTH-1:0] widen(logic signed [VALUE_WIDTH-1:0] v);
    return {{(RESULT_WIDTH-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
  endfunction

  // the aggregate of the open bucket under the mode in force right now
  function automatic bucket_result_t aggregate_bucket(logic last_flag);
    bucket_result_t r;
    logic [RESULT_WIDTH-1:0] magnitude;
    logic [RESULT_WIDTH-1:0] quotient;
    r = '0;
    r.start = cur_bucket_start;
    r.last  = last_flag;
    case (cfg_mode)
      MODE_TOTAL: r.value = bucket_total;
      MODE_AVERAGE: begin
        // divide magnitudes so the quotient truncates toward zero
        magnitude = bucket_total[RESULT_WIDTH-1] ? -bucket_total : bucket_total;
        quotient  = magnitude / RESULT_WIDTH'(bucket_count);
        r.value   = bucket_total[RESULT_WIDTH-1] ? -quotient : quotient;
      end
      MODE_COUNT: r.value = RESULT_WIDTH'(bucket_count) << FRAC_BITS;
      MODE_MINIMUM, MODE_MAXIMUM: begin
        r.value   = widen(bucket_extreme);
        r.quality = extreme_hit ? extreme_qual : '0;
      end
      MODE_FIRST: begin
        r.value   = widen(bucket_first.value);
        r.quality = bucket_first.quality;
      end
      MODE_LAST: begin
        r.value   = widen(bucket_latest.value);
        r.quality = bucket_latest.quality;
      end
      default: r = r;
    endcase
    return r;
  endfunction

  // fold one accepted sample into the model, queue whatever buckets it closes
  task automatic take_sample(sample_item_t s);
    logic [TIME_WIDTH-1:0]          start;
    logic signed [VALUE_WIDTH-1:0]  v;
    logic signed [RESULT_WIDTH:0]   wide;
    logic                           better;
    v     = s.value;
    start = (cfg_interval != 0) ? s.stamp - (s.stamp % cfg_interval) : s.stamp;

    // any change of bucket start, forward or backward, closes the open bucket
    if (have_bucket && start != cur_bucket_start) begin
      pending_buckets.push_back(aggregate_bucket(1'b0));
      have_bucket = 1'b0;
    end
    if (!have_bucket) begin
      have_bucket      = 1'b1;
      cur_bucket_start = start;
      bucket_total     = '0;
      bucket_count     = '0;
      bucket_extreme   = (cfg_mode == MODE_MAXIMUM) ? VALUE_MIN : VALUE_MAX;
      extreme_qual     = '0;
      extreme_hit      = 1'b0;
      bucket_first     = s;
    end
    bucket_latest = s;
    if (bucket_count != COUNT_MAX) bucket_count = bucket_count + 1'b1;

    if (s.ok) begin
      // saturating total
      wide = $signed({bucket_total[RESULT_WIDTH-1], bucket_total}) + widen(v);
      if (wide[RESULT_WIDTH] != wide[RESULT_WIDTH-1]) begin
        bucket_total = wide[RESULT_WIDTH] ? RESULT_MIN : RESULT_MAX;
      end else begin
        bucket_total = wide[RESULT_WIDTH-1:0];
      end
      // strict compare keeps the earliest extreme; a first value equal to the
      // start value still claims it
      if (cfg_mode == MODE_MAXIMUM) begin
        better = (v > bucket_extreme) || (!extreme_hit && v == bucket_extreme);
      end else begin
        better = (v < bucket_extreme) || (!extreme_hit && v == bucket_extreme);
      end
      if (better) begin
        bucket_extreme = v;
        extreme_qual   = s.quality;
      end
      extreme_hit = 1'b1;
    end

    if (s.last) begin
      pending_buckets.push_back(aggregate_bucket(1'b1));
      have_bucket = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // drivers; everything changes on the falling edge
  // --------------------------------------------------------------------------

  // offer one sample beat, with random idle cycles ahead of it
  task automatic send_sample(sample_item_t s);
    while (roll(sender_idle_pct)) begin
      samp.valid <= 1'b0;
      @(negedge clk);
    end
    samp.valid          <= 1'b1;
    samp.sample_time    <= s.stamp;
    samp.sample_value   <= s.value;
    samp.value_valid    <= s.ok;
    samp.sample_quality <= s.quality;
    samp.range_last     <= s.last;
    @(posedge clk);
    while (!samp.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // register write; the model copy follows since the block is idle here
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_AGGREGATE_MODE) begin
      cfg_mode = mode_t'(data);
    end else begin
      cfg_interval = data;
    end
    reg_writes++;
  endtask

  // stop offering, wait for every owed bucket, then let a sample that made no
  // result finish inside the block
  task automatic settle();
    samp.valid <= 1'b0;
    @(negedge clk);
    while (pending_buckets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold-off counted here so the
  // block fills up and pushes back on its input
  initial begin
    int held;
    held      = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_active && held < HOLD_OFF_CYCLES) begin
        held++;
        res.ready <= 1'b0;
      end else begin
        if (!pressure_active) held = 0;
        res.ready <= !roll(receiver_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitors; everything is sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && samp.valid && samp.ready) begin
      take_sample('{samp.sample_time, samp.sample_value, samp.value_valid,
                    samp.sample_quality, samp.range_last});
      samples_taken++;
    end
    // longest run of an offered sample beat being refused
    if (!rst && samp.valid && !samp.ready) begin
      input_stall_run++;
      if (input_stall_run > max_input_stall) max_input_stall = input_stall_run;
    end else begin
      input_stall_run = 0;
    end
  end

  always @(posedge clk) begin
    bucket_result_t got;
    bucket_result_t want;
    if (!rst && res.valid && res.ready) begin
      got = '{res.bucket_start, res.result_value, res.result_quality, res.result_last};
      if (pending_buckets.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected bucket beat: start %h value %h quality %h last %b",
                   got.start, got.value, got.quality, got.last);
        end
      end else begin
        want = pending_buckets.pop_front();
        if (got.start !== want.start || got.value !== want.value ||
            got.quality !== want.quality || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("bucket %0d wrong: start %h/%h value %h/%h quality %h/%h last %b/%b",
                     results_checked, want.start, got.start, want.value, got.value,
                     want.quality, got.quality, want.last, got.last);
          end
        end
      end
      results_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    directed_row_t row;
    sample_item_t  item;
    logic [TIME_WIDTH-1:0]     clock_stamp;
    logic [INTERVAL_WIDTH-1:0] seg_interval;
    int unsigned               step_max;

    // known levels on every input from time zero
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_AGGREGATE_MODE;
    cfg_data            = '0;
    samp.valid          = 1'b0;
    samp.sample_time    = '0;
    samp.sample_value   = '0;
    samp.value_valid    = 1'b0;
    samp.sample_quality = '0;
    samp.range_last     = 1'b0;

    // model matches the block's reset state
    cfg_mode         = MODE_TOTAL;
    cfg_interval     = INTERVAL_RESET;
    have_bucket      = 1'b0;
    cur_bucket_start = '0;
    bucket_total     = '0;
    bucket_count     = '0;
    bucket_extreme   = VALUE_MAX;
    extreme_qual     = '0;
    extreme_hit      = 1'b0;
    bucket_first     = '0;
    bucket_latest    = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed table, light idling on both sides
    sender_idle_pct    = 26;
    receiver_stall_pct = 26;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.set_mode || row.set_interval) begin
        settle();
        if (row.set_mode) write_reg(REG_AGGREGATE_MODE, CFG_DATA_WIDTH'(row.mode));
        if (row.set_interval) write_reg(REG_BUCKET_INTERVAL, row.interval);
      end
      send_sample(row.item);
      // a hand-worked answer stands in for the newest owed bucket; where the
      // sample also closed an earlier bucket, that one stays with the model
      if (row.known) pending_buckets[pending_buckets.size()-1] = row.outcome;
    end

    // random segments: each picks a mode, an interval and an idling pattern
    clock_stamp = '0;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
        default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
      endcase
      case (seg % 5)
        0: seg_interval = INTERVAL_WIDTH'($urandom_range(2, 16));
        1: seg_interval = INTERVAL_RESET;
        2: seg_interval = INTERVAL_TOP;
        3: seg_interval = INTERVAL_WIDTH'(1);
        default: seg_interval = INTERVAL_WIDTH'({$urandom, $urandom}) | INTERVAL_WIDTH'(1);
      endcase
      write_reg(REG_AGGREGATE_MODE, CFG_DATA_WIDTH'(mode_t'(seg % 8)));
      write_reg(REG_BUCKET_INTERVAL, seg_interval);
      // start near the top of the time range when the interval is widest
      if (seg % 5 == 2) clock_stamp = INTERVAL_TOP - $urandom_range(0, 3000);
      step_max = (cfg_interval > STEP_CAP) ? STEP_CAP : 32'(cfg_interval);
      // long result hold-off in one segment, one with no idling, while samples keep coming
      pressure_active = (seg == 4);

      repeat (SEGMENT_ITEMS) begin
        // mostly forward time inside and across buckets, some jumps and
        // backward steps as broken sequences
        case ($urandom_range(0, 19))
          0: clock_stamp = TIME_WIDTH'({$urandom, $urandom});
          1: clock_stamp = clock_stamp - $urandom_range(1, 5000);
          2, 3, 4, 5: clock_stamp = clock_stamp;
          default: clock_stamp = clock_stamp + $urandom_range(0, step_max);
        endcase
        item.stamp = clock_stamp;
        case ($urandom_range(0, 5))
          0: item.value = VALUE_MAX;
          1: item.value = VALUE_MIN;
          2: item.value = ($urandom_range(0, 16) - 8) << FRAC_BITS;
          default: item.value = $urandom;
        endcase
        item.ok      = ($urandom_range(0, 4) != 0);
        item.quality = QUALITY_WIDTH'($urandom);
        item.last    = ($urandom_range(0, 9) == 0);
        send_sample(item);
      end
    end
    settle();
    pressure_active = 1'b0;

    $display("covered %0d samples, %0d bucket beats, %0d register writes",
             samples_taken, results_checked, reg_writes);
    $display("all mode codes and interval extremes used; longest input stall %0d cycles",
             max_input_stall);
    if (mismatch_count == 0 && pending_buckets.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #3ms;
    $display("timeout with %0d bucket beats outstanding", pending_buckets.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
src/tba_pkg.sv
src/tba_sample_if.sv
src/tba_result_if.sv
src/tba_div.sv
src/time_bucket_aggregator.sv
tb/time_bucket_aggregator_test.sv
